// ===== sv/bva_pkg.sv =====
package bva_pkg;

    localparam int unsigned OP_W  = 5;
    localparam int unsigned BUS_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_NEG  = 5'd2,
        OP_MUL  = 5'd3,
        OP_UDIV = 5'd4,
        OP_UREM = 5'd5,
        OP_AND  = 5'd6,
        OP_OR   = 5'd7,
        OP_XOR  = 5'd8,
        OP_NOT  = 5'd9,
        OP_SHL  = 5'd10,
        OP_LSHR = 5'd11,
        OP_ASHR = 5'd12,
        OP_ULT  = 5'd13,
        OP_ULE  = 5'd14,
        OP_SLT  = 5'd15,
        OP_SLE  = 5'd16,
        OP_EQ   = 5'd17
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [BUS_W-1:0] operand_a;
        logic [BUS_W-1:0] operand_b;
    } bva_in_t;

    typedef struct packed {
        logic [BUS_W-1:0] result_value;
        logic             compare_true;
    } bva_out_t;

endpackage

// ===== sv/bva_cell.sv =====
// One stage of the pipeline. Each cell retires one quotient bit of a restoring
// division and accumulates one partial product of the multiplication, then
// hands the whole word to its right neighbor.
module bva_cell
    import bva_pkg::*;
#(
    parameter int unsigned W = 64,
    parameter int unsigned K = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vld_in,
    input  logic [OP_W-1:0] op_in,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] prod_in,
    output logic         vld_out,
    output logic [OP_W-1:0] op_out,
    output logic [W-1:0] a_out,
    output logic [W-1:0] b_out,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] quo_out,
    output logic [W-1:0] prod_out
);

    localparam int unsigned BIT = W - 1 - K;

    logic            vld_reg;
    logic [OP_W-1:0] op_reg;
    logic [W-1:0]    a_reg, b_reg, rem_reg, quo_reg, prod_reg;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic [W-1:0]    rem_next, quo_next, prod_next, pp;

    always_comb
    begin
        trial     = {rem_in, a_in[BIT]};
        diff      = trial - {1'b0, b_in};
        quo_next  = quo_in;
        if (!diff[W])
        begin
            rem_next      = diff[W-1:0];
            quo_next[BIT] = 1'b1;
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
        pp        = b_in[K] ? (a_in << K) : '0;
        prod_next = prod_in + pp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_in;
        a_reg    <= a_in;
        b_reg    <= b_in;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
    end

    assign vld_out  = vld_reg;
    assign op_out   = op_reg;
    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign prod_out = prod_reg;

endmodule

// ===== sv/bva_final.sv =====
// Last stage: picks the result for the opcode and registers it.
module bva_final
    import bva_pkg::*;
#(
    parameter int unsigned W = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vld_in,
    input  logic [OP_W-1:0] op_in,
    input  logic [W-1:0]    a_in,
    input  logic [W-1:0]    b_in,
    input  logic [W-1:0]    rem_in,
    input  logic [W-1:0]    quo_in,
    input  logic [W-1:0]    prod_in,
    output logic            vld_out,
    output bva_out_t        res_out
);

    localparam int unsigned SH_W = (W > 1) ? $clog2(W) : 1;

    logic            vld_reg;
    bva_out_t        res_reg, res_next;
    logic [W-1:0]    r;
    logic            c, big, sa, sb;
    logic [SH_W-1:0] sh;

    always_comb
    begin
        big = (b_in >= W'(W));
        sh  = b_in[SH_W-1:0];
        sa  = a_in[W-1];
        sb  = b_in[W-1];
        r   = '0;
        c   = 1'b0;
        case (op_in)
            OP_ADD:  r = a_in + b_in;
            OP_SUB:  r = a_in - b_in;
            OP_NEG:  r = '0 - a_in;
            OP_MUL:  r = prod_in;
            OP_UDIV: r = (b_in == '0) ? '1 : quo_in;
            OP_UREM: r = (b_in == '0) ? a_in : rem_in;
            OP_AND:  r = a_in & b_in;
            OP_OR:   r = a_in | b_in;
            OP_XOR:  r = a_in ^ b_in;
            OP_NOT:  r = ~a_in;
            OP_SHL:  r = big ? '0 : (a_in << sh);
            OP_LSHR: r = big ? '0 : (a_in >> sh);
            OP_ASHR: r = big ? {W{sa}} : W'($signed(a_in) >>> sh);
            OP_ULT:  c = a_in < b_in;
            OP_ULE:  c = a_in <= b_in;
            OP_SLT:  c = (sa != sb) ? sa : (a_in < b_in);
            OP_SLE:  c = (sa != sb) ? sa : (a_in <= b_in);
            OP_EQ:   c = a_in == b_in;
            default: ;
        endcase
        res_next.result_value = BUS_W'(r);
        res_next.compare_true = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign vld_out = vld_reg;
    assign res_out = res_reg;

endmodule

// ===== sv/bitvector_alu_top.sv =====
// Path: an accepted word passes through the WIDTH registered cells and then the registered
// output stage; the result strobe rises together with the result.
// Throughput: one word per cycle; busy is always low.
// The pipeline is a row of WIDTH cells, one quotient bit and one partial product each.
// Reset clears all valid flags so no strobe appears until a word has passed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bitvector_alu_top
    import bva_pkg::*;
#(
    parameter int unsigned WIDTH = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bva_in_t  cmd,
    output logic     done,
    output bva_out_t result
);

    // Chain wiring: index k feeds cell k.
    logic            vld  [WIDTH+1];
    logic [OP_W-1:0] op   [WIDTH+1];
    logic [WIDTH-1:0] a   [WIDTH+1];
    logic [WIDTH-1:0] b   [WIDTH+1];
    logic [WIDTH-1:0] rem [WIDTH+1];
    logic [WIDTH-1:0] quo [WIDTH+1];
    logic [WIDTH-1:0] prod[WIDTH+1];

    // Each word enters at once; the pipeline never holds off the sender.
    assign busy = 1'b0;

    // Operands are cut to WIDTH bits at the door, so no cell sees upper bits.
    assign vld[0]  = start && !busy;
    assign op[0]   = cmd.operation;
    assign a[0]    = cmd.operand_a[WIDTH-1:0];
    assign b[0]    = cmd.operand_b[WIDTH-1:0];
    assign rem[0]  = '0;
    assign quo[0]  = '0;
    assign prod[0] = '0;

    for (genvar k = 0; k < WIDTH; k++)
    begin : g_cell
        bva_cell #(.W(WIDTH), .K(k)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .vld_in(vld[k]), .op_in(op[k]), .a_in(a[k]), .b_in(b[k]),
            .rem_in(rem[k]), .quo_in(quo[k]), .prod_in(prod[k]),
            .vld_out(vld[k+1]), .op_out(op[k+1]), .a_out(a[k+1]), .b_out(b[k+1]),
            .rem_out(rem[k+1]), .quo_out(quo[k+1]), .prod_out(prod[k+1])
        );
    end

    bva_final #(.W(WIDTH)) u_final (
        .clk(clk), .rst_n(rst_n),
        .vld_in(vld[WIDTH]), .op_in(op[WIDTH]), .a_in(a[WIDTH]), .b_in(b[WIDTH]),
        .rem_in(rem[WIDTH]), .quo_in(quo[WIDTH]), .prod_in(prod[WIDTH]),
        .vld_out(done), .res_out(result)
    );

    // A set comparison flag never comes with a value.
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.compare_true |-> result.result_value == '0)
        else $error("compare result carries a value");

    // A word leaving the last cell is strobed out on the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        vld[WIDTH] |=> done)
        else $error("result strobe lost");

    // Upper bits beyond WIDTH stay clear.
    a_upper: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.result_value >> WIDTH) == '0)
        else $error("result bits above WIDTH set");

endmodule
